FILE: src/contour_band_cell_clipper_top_defines.svh
// Assertion macros for the files that check themselves.
`ifndef CONTOUR_BAND_CELL_CLIPPER_TOP_DEFINES_SVH
`define CONTOUR_BAND_CELL_CLIPPER_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle, outside reset.
`define CBCC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition holds on every cycle outside reset.
`define CBCC_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

`endif

FILE: src/cbcc_pkg.sv
package cbcc_pkg;

   localparam int MAX_VERTS = 8;
   localparam int VIDX_W    = 3;
   localparam int NV_W      = 4;

   // heights widened so that the infinity codes sit outside any finite value
   localparam logic signed [41:0] ZPOS_INF = 42'sh100_0000_0000;
   localparam logic signed [41:0] ZNEG_INF = -42'sh100_0000_0000;

   localparam logic [31:0] CODE_NEG_INF = 32'h8000_0000;
   localparam logic [31:0] CODE_POS_INF = 32'h7FFF_FFFF;

   localparam logic [63:0] AREA_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] AREA_MIN = 64'h8000_0000_0000_0000;

   // number of quotient steps of the serial interpolator
   localparam logic [5:0] DIV_STEPS = 6'd33;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_A1,
      KIND_A2,
      KIND_INTERP
   } cbcc_kind_type;

   // one word between front and back: a vertex job or the end-of-cell mark
   typedef struct packed {
      logic               end_mark;
      logic               swap;
      logic signed [31:0] a_start;
      logic signed [31:0] a_end;
      logic signed [31:0] fixed;
      logic [32:0]        num;
      logic [32:0]        den;
      logic [7:0]         tag;
   } cbcc_req_type;

   typedef enum logic [3:0] {
      ST_FETCH,
      ST_DIV,
      ST_STORE,
      ST_MULA,
      ST_MULB,
      ST_MULC,
      ST_FIN1,
      ST_FIN2,
      ST_RD,
      ST_OUT
   } cbcc_state_type;

endpackage

FILE: src/cbcc_fifo.sv
module cbcc_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  cbcc_pkg::cbcc_req_type push_data,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output cbcc_pkg::cbcc_req_type pop_data,
   output logic [$clog2(DEPTH+1)-1:0] level
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);

   cbcc_pkg::cbcc_req_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign push_ready = (cnt_ff != CNT_W'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign level      = cnt_ff;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // advance pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (!do_push && do_pop) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // store the word
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: src/cbcc_front.sv
module cbcc_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [31:0]     req_cell_x_left,
   input  logic signed [31:0]     req_cell_x_right,
   input  logic signed [31:0]     req_cell_y_low,
   input  logic signed [31:0]     req_cell_y_high,
   input  logic signed [31:0]     req_corner_z_ll,
   input  logic signed [31:0]     req_corner_z_rl,
   input  logic signed [31:0]     req_corner_z_lh,
   input  logic signed [31:0]     req_corner_z_rh,
   input  logic signed [31:0]     req_band_low,
   input  logic signed [31:0]     req_band_high,
   input  logic [7:0]             req_band_tag,
   output logic                   push_valid,
   input  logic                   push_ready,
   output cbcc_pkg::cbcc_req_type push_data
);

   logic               busy_ff, busy_in;
   logic [3:0]         slot_ff, slot_in;
   logic signed [31:0] xl_ff, xr_ff, yl_ff, yh_ff;
   logic signed [31:0] zll_ff, zrl_ff, zlh_ff, zrh_ff;
   logic signed [31:0] blo_ff, bhi_ff;
   logic [7:0]         tag_ff;

   logic signed [31:0] a1, a2, fx, z1_raw, z2_raw;
   logic               swap, part, is_mark, en, advance, accept;
   logic signed [41:0] z1, z2, lo, hi;
   logic signed [41:0] f_num, f_den, s_num, s_den;
   cbcc_pkg::cbcc_kind_type f_kind, s_kind, kind;

   // map a height code to the widened scale, infinities outside the finite range
   function automatic logic signed [41:0] zmap(input logic [31:0] raw);
      logic signed [41:0] r;
      if (raw == cbcc_pkg::CODE_NEG_INF) begin
         r = cbcc_pkg::ZNEG_INF;
      end else if (raw == cbcc_pkg::CODE_POS_INF) begin
         r = cbcc_pkg::ZPOS_INF;
      end else begin
         r = {{10{raw[31]}}, raw};
      end
      return r;
   endfunction

   assign req_ready = !busy_ff;
   assign accept    = req_valid && req_ready;
   assign part      = slot_ff[0];
   assign is_mark   = slot_ff[3];

   // select the edge in ring order
   always_comb begin
      case (slot_ff[2:1])
         2'd0: begin
            a1 = xl_ff; a2 = xr_ff; fx = yl_ff; z1_raw = zll_ff; z2_raw = zrl_ff; swap = 1'b0;
         end
         2'd1: begin
            a1 = yl_ff; a2 = yh_ff; fx = xr_ff; z1_raw = zrl_ff; z2_raw = zrh_ff; swap = 1'b1;
         end
         2'd2: begin
            a1 = xr_ff; a2 = xl_ff; fx = yh_ff; z1_raw = zrh_ff; z2_raw = zlh_ff; swap = 1'b0;
         end
         default: begin
            a1 = yh_ff; a2 = yl_ff; fx = xl_ff; z1_raw = zlh_ff; z2_raw = zll_ff; swap = 1'b1;
         end
      endcase
   end

   assign z1 = zmap(z1_raw);
   assign z2 = zmap(z2_raw);
   assign lo = {{10{blo_ff[31]}}, blo_ff};
   assign hi = {{10{bhi_ff[31]}}, bhi_ff};

   // classify both vertices the edge can yield
   always_comb begin
      f_kind = cbcc_pkg::KIND_NONE;
      s_kind = cbcc_pkg::KIND_NONE;
      f_num  = '0;
      f_den  = 42'sd1;
      s_num  = '0;
      s_den  = 42'sd1;
      if (z1 > z2) begin
         f_num = z1 - hi;
         f_den = z1 - z2;
         s_num = lo - z2;
         s_den = z1 - z2;
         if (!(z2 > hi || z1 < lo)) begin
            if (z1 < hi) begin
               f_kind = cbcc_pkg::KIND_A1;
            end else if (z1 == cbcc_pkg::ZPOS_INF) begin
               f_kind = cbcc_pkg::KIND_A2;
            end else if (z2 == cbcc_pkg::ZNEG_INF) begin
               f_kind = cbcc_pkg::KIND_A1;
            end else begin
               f_kind = cbcc_pkg::KIND_INTERP;
            end
            if (z2 == cbcc_pkg::ZNEG_INF) begin
               s_kind = cbcc_pkg::KIND_A1;
            end else if (z2 <= lo) begin
               s_kind = (z1 == cbcc_pkg::ZPOS_INF) ? cbcc_pkg::KIND_A2
                                                    : cbcc_pkg::KIND_INTERP;
            end
         end
      end else if (z1 < z2) begin
         f_num = lo - z1;
         f_den = z2 - z1;
         s_num = z2 - hi;
         s_den = z2 - z1;
         if (!(z2 < lo || z1 > hi)) begin
            if (z1 > lo) begin
               f_kind = cbcc_pkg::KIND_A1;
            end else if (z1 == cbcc_pkg::ZNEG_INF) begin
               f_kind = cbcc_pkg::KIND_A2;
            end else if (z2 == cbcc_pkg::ZPOS_INF) begin
               f_kind = cbcc_pkg::KIND_A1;
            end else begin
               f_kind = cbcc_pkg::KIND_INTERP;
            end
            if (z2 >= hi) begin
               if (z2 == cbcc_pkg::ZPOS_INF) begin
                  s_kind = cbcc_pkg::KIND_A1;
               end else begin
                  s_kind = (z1 == cbcc_pkg::ZNEG_INF) ? cbcc_pkg::KIND_A2
                                                       : cbcc_pkg::KIND_INTERP;
               end
            end
         end
      end else begin
         if (lo <= z1 && z1 <= hi) begin
            f_kind = cbcc_pkg::KIND_A1;
         end
      end
   end

   // build the word for the current slot
   always_comb begin
      kind = part ? s_kind : f_kind;
      en   = is_mark || (kind != cbcc_pkg::KIND_NONE);
      push_data.end_mark = is_mark;
      push_data.swap     = swap;
      push_data.fixed    = fx;
      push_data.tag      = tag_ff;
      push_data.a_end    = part ? a1 : a2;
      push_data.num      = '0;
      push_data.den      = 33'd1;
      case (kind)
         cbcc_pkg::KIND_A1:     push_data.a_start = a1;
         cbcc_pkg::KIND_A2:     push_data.a_start = a2;
         cbcc_pkg::KIND_INTERP: begin
            push_data.a_start = part ? a2 : a1;
            push_data.num     = part ? s_num[32:0] : f_num[32:0];
            push_data.den     = part ? s_den[32:0] : f_den[32:0];
         end
         default:               push_data.a_start = a1;
      endcase
   end

   assign push_valid = busy_ff && en;
   assign advance    = busy_ff && (!en || push_ready);

   // step through the eight vertex slots and the end mark
   always_comb begin
      busy_in = busy_ff;
      slot_in = slot_ff;
      if (accept) begin
         busy_in = 1'b1;
         slot_in = '0;
      end else if (advance) begin
         slot_in = slot_ff + 4'd1;
         if (is_mark) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         slot_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         slot_ff <= slot_in;
      end
   end

   // hold the cell
   always_ff @(posedge clock) begin
      if (accept) begin
         xl_ff  <= req_cell_x_left;
         xr_ff  <= req_cell_x_right;
         yl_ff  <= req_cell_y_low;
         yh_ff  <= req_cell_y_high;
         zll_ff <= req_corner_z_ll;
         zrl_ff <= req_corner_z_rl;
         zlh_ff <= req_corner_z_lh;
         zrh_ff <= req_corner_z_rh;
         blo_ff <= req_band_low;
         bhi_ff <= req_band_high;
         tag_ff <= req_band_tag;
      end
   end

endmodule

FILE: src/cbcc_back.sv
module cbcc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  cbcc_pkg::cbcc_req_type pop_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [31:0]     rsp_vert_x,
   output logic signed [31:0]     rsp_vert_y,
   output logic [2:0]             rsp_vertex_index,
   output logic                   rsp_last_vertex,
   output logic signed [63:0]     rsp_ring_area,
   output logic [7:0]             rsp_result_tag
);

   localparam int VW = cbcc_pkg::VIDX_W;
   localparam int NW = cbcc_pkg::NV_W;

   cbcc_pkg::cbcc_state_type state_ff, state_in;

   // vertex store
   logic [63:0] vmem [cbcc_pkg::MAX_VERTS];
   logic [63:0] rdata_ff;

   logic [NW-1:0]      nv_ff;
   logic [VW-1:0]      idx_ff;
   logic               closing_ff, neg_ff;
   logic [5:0]         cnt_ff;
   logic signed [31:0] as_ff, fixed_ff;
   logic               swap_ff, dneg_ff;
   logic [32:0]        num_ff, den_ff, mag_ff, r_ff;
   logic [33:0]        q_ff;
   logic signed [31:0] first_x_ff, first_y_ff, prev_x_ff, prev_y_ff, cur_x_ff, cur_y_ff;
   logic signed [63:0] prod_ff;
   logic signed [67:0] acc_ff;
   logic [67:0]        rnd_ff;
   logic [63:0]        area_ff;
   logic [7:0]         tag_ff;

   logic               rsp_valid_ff;
   logic signed [31:0] out_x_ff, out_y_ff;
   logic [VW-1:0]      out_idx_ff;
   logic               out_last_ff;
   logic [63:0]        out_area_ff;
   logic [7:0]         out_tag_ff;

   logic               do_pop, mem_we, rsp_load, is_last, out_free;
   logic signed [32:0] d_full;
   logic [34:0]        t0, t1, t2;
   logic               c1, c2;
   logic signed [33:0] along_w;
   logic signed [31:0] vx, vy;
   logic [66:0]        half;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign is_last  = ({1'b0, idx_ff} == nv_ff - NW'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cbcc_pkg::ST_FETCH: begin
            if (pop_valid) begin
               if (pop_data.end_mark) begin
                  state_in = (nv_ff > NW'(2)) ? cbcc_pkg::ST_MULA : cbcc_pkg::ST_FETCH;
               end else begin
                  state_in = (pop_data.num == '0) ? cbcc_pkg::ST_STORE : cbcc_pkg::ST_DIV;
               end
            end
         end
         cbcc_pkg::ST_DIV:   state_in = (cnt_ff == 6'd1) ? cbcc_pkg::ST_STORE : cbcc_pkg::ST_DIV;
         cbcc_pkg::ST_STORE: state_in = (nv_ff == '0) ? cbcc_pkg::ST_FETCH : cbcc_pkg::ST_MULA;
         cbcc_pkg::ST_MULA:  state_in = cbcc_pkg::ST_MULB;
         cbcc_pkg::ST_MULB:  state_in = cbcc_pkg::ST_MULC;
         cbcc_pkg::ST_MULC:  state_in = closing_ff ? cbcc_pkg::ST_FIN1 : cbcc_pkg::ST_FETCH;
         cbcc_pkg::ST_FIN1:  state_in = (acc_ff == '0) ? cbcc_pkg::ST_FETCH : cbcc_pkg::ST_FIN2;
         cbcc_pkg::ST_FIN2:  state_in = cbcc_pkg::ST_RD;
         cbcc_pkg::ST_RD:    state_in = cbcc_pkg::ST_OUT;
         cbcc_pkg::ST_OUT: begin
            if (out_free) begin
               state_in = is_last ? cbcc_pkg::ST_FETCH : cbcc_pkg::ST_RD;
            end
         end
         default:            state_in = cbcc_pkg::ST_FETCH;
      endcase
   end

   // control strobes
   always_comb begin
      do_pop   = (state_ff == cbcc_pkg::ST_FETCH) && pop_valid;
      mem_we   = (state_ff == cbcc_pkg::ST_STORE);
      rsp_load = (state_ff == cbcc_pkg::ST_OUT) && out_free;
   end

   assign pop_ready = (state_ff == cbcc_pkg::ST_FETCH);

   // one quotient bit step: double, add num on a set bit, take out den up to twice
   always_comb begin
      t0 = {1'b0, r_ff, 1'b0} + (mag_ff[32] ? {2'b00, num_ff} : 35'd0);
      c1 = (t0 >= {2'b00, den_ff});
      t1 = c1 ? t0 - {2'b00, den_ff} : t0;
      c2 = (t1 >= {2'b00, den_ff});
      t2 = c2 ? t1 - {2'b00, den_ff} : t1;
   end

   assign d_full  = {pop_data.a_end[31], pop_data.a_end} - {pop_data.a_start[31], pop_data.a_start};
   assign along_w = dneg_ff ? {as_ff[31], as_ff[31], as_ff} - $signed(q_ff)
                            : {as_ff[31], as_ff[31], as_ff} + $signed(q_ff);
   assign vx      = swap_ff ? fixed_ff : along_w[31:0];
   assign vy      = swap_ff ? along_w[31:0] : fixed_ff;
   assign half    = rnd_ff[67:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cbcc_pkg::ST_FETCH;
         nv_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (do_pop && pop_data.end_mark && nv_ff <= NW'(2)) begin
            nv_ff <= '0;
         end else if (mem_we) begin
            nv_ff <= nv_ff + NW'(1);
         end else if (state_ff == cbcc_pkg::ST_FIN1 && acc_ff == '0) begin
            nv_ff <= '0;
         end else if (rsp_load && is_last) begin
            nv_ff <= '0;
         end
      end
   end

   // datapath: interpolation, area accumulation, rounding, readout
   always_ff @(posedge clock) begin
      case (state_ff)
         cbcc_pkg::ST_FETCH: begin
            if (do_pop) begin
               if (pop_data.end_mark) begin
                  tag_ff     <= pop_data.tag;
                  closing_ff <= 1'b1;
                  cur_x_ff   <= first_x_ff;
                  cur_y_ff   <= first_y_ff;
                  if (nv_ff <= NW'(2)) begin
                     acc_ff <= '0;
                  end
               end else begin
                  closing_ff <= 1'b0;
                  as_ff      <= pop_data.a_start;
                  fixed_ff   <= pop_data.fixed;
                  swap_ff    <= pop_data.swap;
                  num_ff     <= pop_data.num;
                  den_ff     <= pop_data.den;
                  dneg_ff    <= d_full[32];
                  mag_ff     <= d_full[32] ? 33'(-d_full) : d_full;
                  r_ff       <= '0;
                  q_ff       <= '0;
                  cnt_ff     <= cbcc_pkg::DIV_STEPS;
               end
            end
         end
         cbcc_pkg::ST_DIV: begin
            r_ff   <= t2[32:0];
            q_ff   <= {q_ff[32:0], 1'b0} + {33'd0, c1} + {33'd0, c2};
            mag_ff <= {mag_ff[31:0], 1'b0};
            cnt_ff <= cnt_ff - 6'd1;
         end
         cbcc_pkg::ST_STORE: begin
            cur_x_ff <= vx;
            cur_y_ff <= vy;
            if (nv_ff == '0) begin
               first_x_ff <= vx;
               first_y_ff <= vy;
               prev_x_ff  <= vx;
               prev_y_ff  <= vy;
               acc_ff     <= '0;
            end
         end
         cbcc_pkg::ST_MULA: begin
            prod_ff <= prev_x_ff * cur_y_ff;
         end
         cbcc_pkg::ST_MULB: begin
            acc_ff  <= acc_ff + {{4{prod_ff[63]}}, prod_ff};
            prod_ff <= prev_y_ff * cur_x_ff;
         end
         cbcc_pkg::ST_MULC: begin
            acc_ff    <= acc_ff - {{4{prod_ff[63]}}, prod_ff};
            prev_x_ff <= cur_x_ff;
            prev_y_ff <= cur_y_ff;
         end
         cbcc_pkg::ST_FIN1: begin
            neg_ff <= acc_ff[67];
            rnd_ff <= acc_ff[67] ? (~acc_ff) + 68'd2 : acc_ff + 68'd1;
            idx_ff <= '0;
         end
         cbcc_pkg::ST_FIN2: begin
            if (!neg_ff) begin
               area_ff <= (half[66:63] != '0) ? cbcc_pkg::AREA_MAX : half[63:0];
            end else begin
               area_ff <= (half[66:63] != '0) ? cbcc_pkg::AREA_MIN : 64'd0 - half[63:0];
            end
         end
         cbcc_pkg::ST_OUT: begin
            if (rsp_load) begin
               idx_ff <= idx_ff + VW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // vertex memory: write on store, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         vmem[nv_ff[VW-1:0]] <= {vx, vy};
      end
      rdata_ff <= vmem[idx_ff];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         out_x_ff    <= rdata_ff[63:32];
         out_y_ff    <= rdata_ff[31:0];
         out_idx_ff  <= idx_ff;
         out_last_ff <= is_last;
         out_area_ff <= area_ff;
         out_tag_ff  <= tag_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vert_x       = out_x_ff;
   assign rsp_vert_y       = out_y_ff;
   assign rsp_vertex_index = out_idx_ff;
   assign rsp_last_vertex  = out_last_ff;
   assign rsp_ring_area    = out_area_ff;
   assign rsp_result_tag   = out_tag_ff;

endmodule

FILE: src/contour_band_cell_clipper_top.sv
// The front accepts a cell, then walks nine slots. In the back a direct vertex passes FETCH and
// STORE, an interpolated vertex also the serial 33-step interpolation divider, and each vertex
// after the first adds MULA, MULB and MULC for area. Closing a ring passes MULA to MULC, FIN1 and
// FIN2, then RD and OUT per emitted vertex. The front takes no new cell before its slots are done;
// a ring holds the back end for its whole pass, so cells that emit pace the input through the queue.
// Reset clears all control state at once; no clearing pass is needed.
`include "contour_band_cell_clipper_top_defines.svh"

module contour_band_cell_clipper_top #(
   parameter int FIFO_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_cell_x_left,
   input  logic signed [31:0] req_cell_x_right,
   input  logic signed [31:0] req_cell_y_low,
   input  logic signed [31:0] req_cell_y_high,
   input  logic signed [31:0] req_corner_z_ll,
   input  logic signed [31:0] req_corner_z_rl,
   input  logic signed [31:0] req_corner_z_lh,
   input  logic signed [31:0] req_corner_z_rh,
   input  logic signed [31:0] req_band_low,
   input  logic signed [31:0] req_band_high,
   input  logic [7:0]         req_band_tag,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_vert_x,
   output logic signed [31:0] rsp_vert_y,
   output logic [2:0]         rsp_vertex_index,
   output logic               rsp_last_vertex,
   output logic signed [63:0] rsp_ring_area,
   output logic [7:0]         rsp_result_tag
);

   cbcc_pkg::cbcc_req_type push_data, pop_data;
   logic push_valid, push_ready, pop_valid, pop_ready;
   logic [$clog2(FIFO_DEPTH+1)-1:0] fifo_level;

   cbcc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cell_x_left  (req_cell_x_left),
      .req_cell_x_right (req_cell_x_right),
      .req_cell_y_low   (req_cell_y_low),
      .req_cell_y_high  (req_cell_y_high),
      .req_corner_z_ll  (req_corner_z_ll),
      .req_corner_z_rl  (req_corner_z_rl),
      .req_corner_z_lh  (req_corner_z_lh),
      .req_corner_z_rh  (req_corner_z_rh),
      .req_band_low     (req_band_low),
      .req_band_high    (req_band_high),
      .req_band_tag     (req_band_tag),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_data        (push_data)
   );

   cbcc_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .level      (fifo_level)
   );

   cbcc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_data         (pop_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_vert_x       (rsp_vert_x),
      .rsp_vert_y       (rsp_vert_y),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_last_vertex  (rsp_last_vertex),
      .rsp_ring_area    (rsp_ring_area),
      .rsp_result_tag   (rsp_result_tag)
   );

   `CBCC_ASSERT_ALWAYS(a_fifo_bound, fifo_level <= ($clog2(FIFO_DEPTH+1))'(FIFO_DEPTH), "queue level beyond depth")
   `CBCC_ASSERT_IMPLIES(a_full_push, fifo_level == ($clog2(FIFO_DEPTH+1))'(FIFO_DEPTH), !push_ready, "push accepted while queue full")
   `CBCC_ASSERT_IMPLIES(a_area_nonzero, rsp_valid, rsp_ring_area != 64'sd0, "ring emitted with zero area")
   `CBCC_ASSERT_IMPLIES(a_pop_needs_word, pop_ready && !pop_valid, fifo_level == '0, "queue holds a word that is not offered")

endmodule

FILE: tb/tb_contour_band_cell_clipper_top.sv
module tb_contour_band_cell_clipper_top;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 400;
   localparam int RANDOM_CELLS = 210;

   typedef struct {
      logic [31:0] x_left, x_right, y_low, y_high;
      logic [31:0] z_ll, z_rl, z_lh, z_rh;
      logic [31:0] level_low, level_high;
      logic [7:0]  tag;
   } cell_type;

   typedef struct {
      logic [31:0] vert_x, vert_y;
      logic [2:0]  vertex_index;
      logic        last_vertex;
      logic [63:0] ring_area;
      logic [7:0]  tag;
   } vertex_type;

   typedef enum int {
      H_BELOW, H_AT_LOW, H_INSIDE, H_AT_HIGH, H_ABOVE, H_NEG_INF, H_POS_INF, H_ANY
   } height_kind_type;

   logic        clock, reset;
   logic        req_valid, req_ready;
   logic signed [31:0] req_cell_x_left, req_cell_x_right, req_cell_y_low, req_cell_y_high;
   logic signed [31:0] req_corner_z_ll, req_corner_z_rl, req_corner_z_lh, req_corner_z_rh;
   logic signed [31:0] req_band_low, req_band_high;
   logic [7:0]  req_band_tag;
   logic        rsp_valid, rsp_ready;
   logic signed [31:0] rsp_vert_x, rsp_vert_y;
   logic [2:0]  rsp_vertex_index;
   logic        rsp_last_vertex;
   logic signed [63:0] rsp_ring_area;
   logic [7:0]  rsp_result_tag;

   vertex_type  pending_vertices[$];
   longint      ring_x[cbcc_pkg::MAX_VERTS];
   longint      ring_y[cbcc_pkg::MAX_VERTS];
   int          ring_len;
   int          error_count;
   int          cells_sent;
   int          vertices_checked;
   int          rings_seen;
   int          cycle_count = 0;

   contour_band_cell_clipper_top u_top (.*);

   // free-running clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still expected",
                  cycle_count, pending_vertices.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("[%0t] mismatch on %s: got %h expected %h", $realtime, what, got, want);
   endtask

   // ---------------- prediction ----------------

   function automatic longint height_of(input logic [31:0] code);
      if (code == cbcc_pkg::CODE_NEG_INF) return -(longint'(1) <<< 40);
      if (code == cbcc_pkg::CODE_POS_INF) return longint'(1) <<< 40;
      return longint'($signed(code));
   endfunction

   // point from a_start toward a_end by num/den of the span, truncated
   function automatic longint cross_point(input longint a_start, input longint a_end,
                                          input longint num, input longint den);
      longint      span;
      logic [127:0] prod;
      longint      off;
      if (den <= 0 || num <= 0) return a_start;
      span = a_end - a_start;
      prod = 128'(num) * 128'(span < 0 ? -span : span);
      off  = longint'(prod / 128'(den));
      return span < 0 ? a_start - off : a_start + off;
   endfunction

   function automatic void add_vertex(input longint along, input longint fixed_c,
                                      input bit swap);
      if (ring_len >= cbcc_pkg::MAX_VERTS) return;
      ring_x[ring_len] = swap ? fixed_c : along;
      ring_y[ring_len] = swap ? along : fixed_c;
      ring_len++;
   endfunction

   function automatic void clip_edge(input longint lo, input longint hi, input longint a1,
                                     input longint a2, input longint f, input longint z1,
                                     input longint z2, input bit swap);
      longint pinf, ninf;
      pinf = longint'(1) <<< 40;
      ninf = -pinf;
      if (z1 > z2) begin
         if (z2 > hi || z1 < lo) return;
         if (z1 < hi) add_vertex(a1, f, swap);
         else if (z1 == pinf) add_vertex(a2, f, swap);
         else add_vertex(z2 == ninf ? a1 : cross_point(a1, a2, z1 - hi, z1 - z2), f, swap);
         if (z2 == ninf) add_vertex(a1, f, swap);
         else if (z2 <= lo)
            add_vertex(z1 == pinf ? a2 : cross_point(a2, a1, lo - z2, z1 - z2), f, swap);
      end else if (z1 < z2) begin
         if (z2 < lo || z1 > hi) return;
         if (z1 > lo) add_vertex(a1, f, swap);
         else if (z1 == ninf) add_vertex(a2, f, swap);
         else add_vertex(z2 == pinf ? a1 : cross_point(a1, a2, lo - z1, z2 - z1), f, swap);
         if (z2 < hi) return;
         if (z2 == pinf) add_vertex(a1, f, swap);
         else add_vertex(z1 == ninf ? a2 : cross_point(a2, a1, z2 - hi, z2 - z1), f, swap);
      end else begin
         if (lo <= z1 && z1 <= hi) add_vertex(a1, f, swap);
      end
   endfunction

   // clip one cell and queue the ring it produces
   function automatic void predict_ring(input cell_type c);
      longint xl, xr, yl, yh, lo, hi;
      logic signed [127:0] twice_area;
      logic [127:0] mag, half;
      logic [63:0]  area;
      vertex_type   v;
      int           j;
      xl = longint'($signed(c.x_left));
      xr = longint'($signed(c.x_right));
      yl = longint'($signed(c.y_low));
      yh = longint'($signed(c.y_high));
      lo = longint'($signed(c.level_low));
      hi = longint'($signed(c.level_high));
      ring_len = 0;
      clip_edge(lo, hi, xl, xr, yl, height_of(c.z_ll), height_of(c.z_rl), 1'b0);
      clip_edge(lo, hi, yl, yh, xr, height_of(c.z_rl), height_of(c.z_rh), 1'b1);
      clip_edge(lo, hi, xr, xl, yh, height_of(c.z_rh), height_of(c.z_lh), 1'b0);
      clip_edge(lo, hi, yh, yl, xl, height_of(c.z_lh), height_of(c.z_ll), 1'b1);
      if (ring_len <= 2) return;
      twice_area = '0;
      for (int k = 0; k < ring_len; k++) begin
         j = (k + 1 < ring_len) ? k + 1 : 0;
         twice_area = twice_area + 128'(ring_x[k] * ring_y[j]) - 128'(ring_y[k] * ring_x[j]);
      end
      if (twice_area == 0) return;
      // halve away from zero, then saturate
      mag  = twice_area < 0 ? -twice_area : twice_area;
      half = (mag + 1) >> 1;
      if (twice_area > 0)
         area = (half > 128'(cbcc_pkg::AREA_MAX)) ? cbcc_pkg::AREA_MAX : half[63:0];
      else
         area = (half >= 128'(cbcc_pkg::AREA_MIN)) ? cbcc_pkg::AREA_MIN : -half[63:0];
      rings_seen++;
      for (int k = 0; k < ring_len; k++) begin
         v.vert_x       = ring_x[k][31:0];
         v.vert_y       = ring_y[k][31:0];
         v.vertex_index = 3'(k);
         v.last_vertex  = (k == ring_len - 1);
         v.ring_area    = area;
         v.tag          = c.tag;
         pending_vertices = {pending_vertices, v};
      end
   endfunction

   // ---------------- checking ----------------

   always @(posedge clock) begin
      vertex_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_vertices.size() == 0) begin
            report_mismatch("unexpected word", {rsp_vert_x, rsp_vert_y}, '0);
         end else begin
            want = pending_vertices.pop_front();
            vertices_checked++;
            if (rsp_vert_x !== want.vert_x) report_mismatch("vert_x", rsp_vert_x, want.vert_x);
            if (rsp_vert_y !== want.vert_y) report_mismatch("vert_y", rsp_vert_y, want.vert_y);
            if (rsp_vertex_index !== want.vertex_index)
               report_mismatch("vertex_index", rsp_vertex_index, want.vertex_index);
            if (rsp_last_vertex !== want.last_vertex)
               report_mismatch("last_vertex", rsp_last_vertex, want.last_vertex);
            if (rsp_ring_area !== want.ring_area)
               report_mismatch("ring_area", rsp_ring_area, want.ring_area);
            if (rsp_result_tag !== want.tag)
               report_mismatch("result_tag", rsp_result_tag, want.tag);
         end
      end
   end

   // receiver: random stall before each word, with stall-free stretches
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // ---------------- stimulus ----------------

   // drive one cell; called at a falling edge, returns at a falling edge
   task automatic send_cell(input cell_type c);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_cell_x_left  <= c.x_left;
      req_cell_x_right <= c.x_right;
      req_cell_y_low   <= c.y_low;
      req_cell_y_high  <= c.y_high;
      req_corner_z_ll  <= c.z_ll;
      req_corner_z_rl  <= c.z_rl;
      req_corner_z_lh  <= c.z_lh;
      req_corner_z_rh  <= c.z_rh;
      req_band_low     <= c.level_low;
      req_band_high    <= c.level_high;
      req_band_tag     <= c.tag;
      req_valid        <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_ring(c);
      cells_sent++;
      @(negedge clock);
   endtask

   function automatic cell_type make_cell(input logic [31:0] xl, xr, yl, yh, zll, zrl,
                                          zlh, zrh, lo, hi);
      cell_type c;
      c = '{xl, xr, yl, yh, zll, zrl, zlh, zrh, lo, hi, 8'($urandom)};
      return c;
   endfunction

   function automatic logic [31:0] pick_height(input logic [31:0] lo, input logic [31:0] hi);
      height_kind_type kind;
      kind = height_kind_type'($urandom_range(0, 7));
      case (kind)
         H_BELOW:   return lo - $urandom_range(1, 32'h0004_0000);
         H_AT_LOW:  return lo;
         H_INSIDE:  return lo + ((hi - lo) >> 1) + $urandom_range(0, 3);
         H_AT_HIGH: return hi;
         H_ABOVE:   return hi + $urandom_range(1, 32'h0004_0000);
         H_NEG_INF: return cbcc_pkg::CODE_NEG_INF;
         H_POS_INF: return cbcc_pkg::CODE_POS_INF;
         default:   return $urandom;
      endcase
   endfunction

   // drop valid, then hold off until every queued word has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_vertices.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed_cells();
      logic [31:0] one;
      one = 32'h0001_0000;
      // all corners inside the band: the full square
      send_cell(make_cell(0, one, 0, one, 5, 5, 5, 5, 0, 10));
      // all below, all above: nothing
      send_cell(make_cell(0, one, 0, one, -20, -20, -20, -20, 0, 10));
      send_cell(make_cell(0, one, 0, one, 50, 50, 50, 50, 0, 10));
      // ramp crossing both levels on two edges: four vertices
      send_cell(make_cell(0, one, 0, one, 0, 40, 0, 40, 10, 30));
      send_cell(make_cell(-one, one, -one, one, 40, 0, 40, 0, 10, 30));
      // corners sitting exactly on the levels
      send_cell(make_cell(0, one, 0, one, 10, 30, 10, 30, 10, 30));
      // inverted band
      send_cell(make_cell(0, one, 0, one, 5, 25, 15, 35, 30, 10));
      // zero-size cell: no area
      send_cell(make_cell(one, one, one, one, 5, 5, 5, 5, 0, 10));
      // widest cells: saturated area both ways, then a wide cell that does not saturate
      send_cell(make_cell(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          0, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF));
      send_cell(make_cell(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                          0, 0, 0, 0, 0, 0));
      send_cell(make_cell(32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF,
                          3, 3, 3, 3, 3, 3));
   endtask

   task automatic test_infinite_corners();
      logic [31:0] one;
      one = 32'h0001_0000;
      // infinite near and far corners
      send_cell(make_cell(0, one, 0, one, cbcc_pkg::CODE_NEG_INF, cbcc_pkg::CODE_POS_INF,
                          cbcc_pkg::CODE_NEG_INF, cbcc_pkg::CODE_POS_INF, 10, 30));
      send_cell(make_cell(0, one, 0, one, cbcc_pkg::CODE_POS_INF, 20,
                          cbcc_pkg::CODE_NEG_INF, 20, 10, 30));
      send_cell(make_cell(0, one, 0, one, 20, cbcc_pkg::CODE_NEG_INF, 20,
                          cbcc_pkg::CODE_POS_INF, 10, 30));
      send_cell(make_cell(0, one, 0, one, cbcc_pkg::CODE_POS_INF, cbcc_pkg::CODE_POS_INF,
                          20, 0, 10, 30));
      send_cell(make_cell(0, one, 0, one, cbcc_pkg::CODE_NEG_INF, 30, 10,
                          cbcc_pkg::CODE_POS_INF, 10, 30));
      send_cell(make_cell(-one, one, -one, one, 0, cbcc_pkg::CODE_POS_INF, 40,
                          cbcc_pkg::CODE_NEG_INF, 10, 30));
      send_cell(make_cell(0, one, 0, one, cbcc_pkg::CODE_NEG_INF, cbcc_pkg::CODE_NEG_INF,
                          cbcc_pkg::CODE_POS_INF, cbcc_pkg::CODE_POS_INF, 10, 30));
   endtask

   task automatic test_drain_pause();
      wait_for_drain();
      send_cell(make_cell(0, 32'h0003_0000, 0, 32'h0002_0000, 0, 100, 200, 50, 40, 160));
   endtask

   task automatic test_random_cells(input int count);
      cell_type    c;
      logic [31:0] lo, hi, xl, yl;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 3) == 0) begin
            // raw noise across the whole field range
            c = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, 8'($urandom)};
         end else begin
            lo = $urandom_range(0, 32'h1FFF_FFFF) - 32'h1000_0000;
            hi = lo + $urandom_range(0, 32'h0010_0000);
            if ($urandom_range(0, 9) == 0) hi = lo - $urandom_range(1, 1000);
            xl = $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
            yl = $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
            c = make_cell(xl, xl + $urandom_range(1, 32'h0100_0000),
                          yl, yl + $urandom_range(1, 32'h0100_0000),
                          pick_height(lo, hi), pick_height(lo, hi),
                          pick_height(lo, hi), pick_height(lo, hi), lo, hi);
         end
         send_cell(c);
         if (n == count / 2) test_drain_pause();
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_cell_x_left  = '0;
      req_cell_x_right = '0;
      req_cell_y_low   = '0;
      req_cell_y_high  = '0;
      req_corner_z_ll  = '0;
      req_corner_z_rl  = '0;
      req_corner_z_lh  = '0;
      req_corner_z_rh  = '0;
      req_band_low     = '0;
      req_band_high    = '0;
      req_band_tag     = '0;
      error_count      = 0;
      cells_sent       = 0;
      vertices_checked = 0;
      rings_seen       = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_cells();
      test_infinite_corners();
      test_random_cells(RANDOM_CELLS);

      // drain, then allow for any ring still in the back end
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("cells sent: %0d, rings predicted: %0d, vertices checked: %0d",
               cells_sent, rings_seen, vertices_checked);
      $display("covered band crossings, infinite corners, inverted bands, area saturation");
      if (error_count == 0 && pending_vertices.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d words never arrived", error_count,
                  pending_vertices.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
